/* rtl/fra_pkg.sv */
// ----------------------------------------------------------------------------
// fra_pkg
// Types, register indexes and the control program of the frame rate averager.
// ----------------------------------------------------------------------------
package fra_pkg;

    localparam int STAMP_W   = 64;
    localparam int RATE_W    = 32;
    localparam int ALPHA_W   = 17;
    localparam int COUNT_W   = 14;
    localparam int WARM_W    = 8;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 32;

    // divider geometry: 48-bit dividend, one quotient bit per step
    localparam int NUM_W  = 48;
    localparam int QCNT_W = 6;
    localparam logic [QCNT_W-1:0] RATE_DIV_STEPS  = 6'd48;
    localparam logic [QCNT_W-1:0] ALPHA_DIV_STEPS = 6'd17;

    localparam logic [ALPHA_W-1:0] ONE_Q16  = 17'h10000;
    localparam logic [RATE_W-1:0]  RATE_SAT = 32'hFFFF_FFFF;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TICK_FREQUENCY = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WARMUP_FRAMES  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEADY_ALPHA   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RESTART_COUNT  = 8'd3;

    // program addresses
    localparam int PC_W = 4;
    localparam logic [PC_W-1:0] PC_IDLE       = 4'd0;
    localparam logic [PC_W-1:0] PC_RATE_LOAD  = 4'd1;
    localparam logic [PC_W-1:0] PC_RATE_LOOP  = 4'd2;
    localparam logic [PC_W-1:0] PC_RATE_SAVE  = 4'd3;
    localparam logic [PC_W-1:0] PC_ALPHA_LOAD = 4'd4;
    localparam logic [PC_W-1:0] PC_ALPHA_LOOP = 4'd5;
    localparam logic [PC_W-1:0] PC_ALPHA_SAVE = 4'd6;
    localparam logic [PC_W-1:0] PC_DIFF       = 4'd7;
    localparam logic [PC_W-1:0] PC_MUL        = 4'd8;
    localparam logic [PC_W-1:0] PC_BLEND      = 4'd9;
    localparam logic [PC_W-1:0] PC_EMIT       = 4'd10;

    typedef enum logic [3:0] {
        OP_IDLE,
        OP_RATE_LOAD,
        OP_DIV_STEP,
        OP_RATE_SAVE,
        OP_ALPHA_LOAD,
        OP_ALPHA_SAVE,
        OP_DIFF,
        OP_MUL,
        OP_BLEND,
        OP_EMIT
    } op_t;

    typedef enum logic [1:0] {
        COND_NEXT,
        COND_ALWAYS,
        COND_DIV_MORE,
        COND_STEADY
    } cond_t;

    typedef struct packed {
        op_t             op;
        cond_t           cond;
        logic [PC_W-1:0] target;
    } ctrl_word_t;

    function automatic ctrl_word_t prog_word(input logic [PC_W-1:0] pc);
        ctrl_word_t w;
        case (pc)
            PC_IDLE:       w = '{OP_IDLE,       COND_NEXT,     PC_IDLE};
            PC_RATE_LOAD:  w = '{OP_RATE_LOAD,  COND_NEXT,     PC_IDLE};
            PC_RATE_LOOP:  w = '{OP_DIV_STEP,   COND_DIV_MORE, PC_RATE_LOOP};
            PC_RATE_SAVE:  w = '{OP_RATE_SAVE,  COND_STEADY,   PC_ALPHA_SAVE};
            PC_ALPHA_LOAD: w = '{OP_ALPHA_LOAD, COND_NEXT,     PC_IDLE};
            PC_ALPHA_LOOP: w = '{OP_DIV_STEP,   COND_DIV_MORE, PC_ALPHA_LOOP};
            PC_ALPHA_SAVE: w = '{OP_ALPHA_SAVE, COND_NEXT,     PC_IDLE};
            PC_DIFF:       w = '{OP_DIFF,       COND_NEXT,     PC_IDLE};
            PC_MUL:        w = '{OP_MUL,        COND_NEXT,     PC_IDLE};
            PC_BLEND:      w = '{OP_BLEND,      COND_NEXT,     PC_IDLE};
            PC_EMIT:       w = '{OP_EMIT,       COND_ALWAYS,   PC_IDLE};
            default:       w = '{OP_IDLE,       COND_ALWAYS,   PC_IDLE};
        endcase
        return w;
    endfunction

endpackage

/* rtl/frame_rate_averager.sv */
// ----------------------------------------------------------------------------
// frame_rate_averager
// Frame rate meter: elapsed ticks between start and end words, rate in Q16.16,
// exponential moving average of the rate, driven by a small microprogram.
// ----------------------------------------------------------------------------
//  channel  | handshake           | payload
//  ---------+---------------------+-----------------------------------------
//  in       | in_valid/in_ready   | operation (0 start, 1 end), timestamp
//  out      | out_valid/out_ready | average_rate (Q16.16)
//  cfg      | cfg_valid/cfg_ready | cfg_index, cfg_data (always ready)
//
//  A start word only stores its timestamp. An end word holds the sequencer
//  through the 48-step rate division and, during warmup only, the 17-step
//  alpha division, both on one restoring divider; steady state skips the latter.
//  in_ready is high only at the idle step; the emit step waits while the output
//  register still holds a word that has not been taken.
//  Reset clears the control and the state and loads the register defaults.
// ----------------------------------------------------------------------------
module frame_rate_averager
    import fra_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 operation,
    input  logic [STAMP_W-1:0]   timestamp,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [RATE_W-1:0]    average_rate,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data
);

    // control and state registers
    logic [PC_W-1:0]    pc_reg,        pc_next;
    logic [RATE_W-1:0]  tick_freq_reg, tick_freq_next;
    logic [WARM_W-1:0]  warmup_reg,    warmup_next;
    logic [ALPHA_W-1:0] steady_reg,    steady_next;
    logic [COUNT_W-1:0] restart_reg,   restart_next;
    logic [STAMP_W-1:0] start_reg,     start_next;
    logic [RATE_W-1:0]  avg_reg,       avg_next;
    logic [COUNT_W-1:0] count_reg,     count_next;
    logic               out_valid_reg, out_valid_next;

    // datapath registers
    logic [STAMP_W-1:0] rem_reg,   rem_next;
    logic [STAMP_W-1:0] div_reg,   div_next;
    logic [NUM_W-1:0]   num_reg,   num_next;
    logic [NUM_W-1:0]   quo_reg,   quo_next;
    logic [QCNT_W-1:0]  cnt_reg,   cnt_next;
    logic [COUNT_W:0]   n_reg,     n_next;
    logic [RATE_W-1:0]  rate_reg,  rate_next;
    logic [ALPHA_W-1:0] alpha_reg, alpha_next;
    logic [RATE_W-1:0]  diff_reg,  diff_next;
    logic               neg_reg,   neg_next;
    logic [RATE_W+ALPHA_W-1:0] prod_reg, prod_next;
    logic [RATE_W-1:0]  out_reg,   out_next;

    ctrl_word_t          ctrl;
    logic                in_fire;
    logic                out_free;
    logic                steady;
    logic                stall;
    logic                jump;
    logic [STAMP_W:0]    trial;
    logic [STAMP_W:0]    trial_sub;
    logic                trial_ge;
    logic [RATE_W+ALPHA_W:0] prod_up;
    logic [ALPHA_W-1:0]  steady_clamped;

    assign ctrl      = prog_word(pc_reg);
    assign in_ready  = (ctrl.op == OP_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign average_rate = out_reg;
    assign out_free  = !out_valid_reg || out_ready;
    assign steady    = (n_reg > {{(COUNT_W+1-WARM_W){1'b0}}, warmup_reg});

    assign steady_clamped = (steady_reg > ONE_Q16) ? ONE_Q16 : steady_reg;

    // restoring divider step: shift in the next dividend bit, subtract if it fits
    assign trial     = {rem_reg, num_reg[NUM_W-1]};
    assign trial_sub = trial - {1'b0, div_reg};
    assign trial_ge  = (trial >= {1'b0, div_reg});

    assign prod_up = {1'b0, prod_reg} + (RATE_W+ALPHA_W+1)'(16'hFFFF);

    // sequencer
    always_comb
    begin
        stall = ((ctrl.op == OP_IDLE) && !(in_fire && operation))
             || ((ctrl.op == OP_EMIT) && !out_free);
        case (ctrl.cond)
            COND_NEXT:     jump = 1'b0;
            COND_ALWAYS:   jump = 1'b1;
            COND_DIV_MORE: jump = (cnt_reg > QCNT_W'(1));
            COND_STEADY:   jump = steady;
            default:       jump = 1'b0;
        endcase
        if (stall)
            pc_next = pc_reg;
        else if (jump)
            pc_next = ctrl.target;
        else
            pc_next = pc_reg + PC_W'(1);
    end

    // datapath
    always_comb
    begin
        tick_freq_next = tick_freq_reg;
        warmup_next    = warmup_reg;
        steady_next    = steady_reg;
        restart_next   = restart_reg;
        start_next     = start_reg;
        avg_next       = avg_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && !out_ready;
        rem_next       = rem_reg;
        div_next       = div_reg;
        num_next       = num_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;
        n_next         = n_reg;
        rate_next      = rate_reg;
        alpha_next     = alpha_reg;
        diff_next      = diff_reg;
        neg_next       = neg_reg;
        prod_next      = prod_reg;
        out_next       = out_reg;

        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_TICK_FREQUENCY: tick_freq_next = cfg_data[RATE_W-1:0];
                REG_WARMUP_FRAMES:  warmup_next    = cfg_data[WARM_W-1:0];
                REG_STEADY_ALPHA:   steady_next    = cfg_data[ALPHA_W-1:0];
                REG_RESTART_COUNT:  restart_next   = cfg_data[COUNT_W-1:0];
                default:            ;
            endcase
        end

        case (ctrl.op)
            OP_IDLE:
            begin
                if (in_fire)
                begin
                    if (operation)
                    begin
                        div_next = timestamp - start_reg;
                        n_next   = {1'b0, count_reg} + (COUNT_W+1)'(1);
                    end
                    else
                        start_next = timestamp;
                end
            end
            OP_RATE_LOAD:
            begin
                num_next = {tick_freq_reg, 16'h0000};
                rem_next = '0;
                quo_next = '0;
                cnt_next = RATE_DIV_STEPS;
            end
            OP_DIV_STEP:
            begin
                rem_next = trial_ge ? trial_sub[STAMP_W-1:0] : trial[STAMP_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], trial_ge};
                num_next = {num_reg[NUM_W-2:0], 1'b0};
                cnt_next = cnt_reg - QCNT_W'(1);
            end
            OP_RATE_SAVE:
            begin
                // saturate on overflow; a zero divisor yields all ones too
                rate_next = (|quo_reg[NUM_W-1:RATE_W]) ? RATE_SAT : quo_reg[RATE_W-1:0];
            end
            OP_ALPHA_LOAD:
            begin
                // dividend 65536 aligned to the top so 17 steps finish the quotient
                num_next = {ONE_Q16, (NUM_W-ALPHA_W)'(0)};
                div_next = {(STAMP_W-COUNT_W-1)'(0), n_reg};
                rem_next = '0;
                quo_next = '0;
                cnt_next = ALPHA_DIV_STEPS;
            end
            OP_ALPHA_SAVE:
                alpha_next = steady ? steady_clamped : quo_reg[ALPHA_W-1:0];
            OP_DIFF:
            begin
                neg_next  = (rate_reg < avg_reg);
                diff_next = (rate_reg < avg_reg) ? (avg_reg - rate_reg)
                                                 : (rate_reg - avg_reg);
            end
            OP_MUL:
                prod_next = diff_reg * alpha_reg;
            OP_BLEND:
            begin
                // floor toward minus infinity on the falling side
                if (neg_reg)
                    avg_next = avg_reg - prod_up[RATE_W+15:16];
                else
                    avg_next = avg_reg + prod_reg[RATE_W+15:16];
                count_next = (n_reg > {1'b0, restart_reg}) ? '0 : n_reg[COUNT_W-1:0];
            end
            OP_EMIT:
            begin
                if (out_free)
                begin
                    out_next       = avg_reg;
                    out_valid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= PC_IDLE;
            tick_freq_reg <= 32'd100000000;
            warmup_reg    <= 8'd50;
            steady_reg    <= 17'd655;
            restart_reg   <= 14'd10000;
            start_reg     <= '0;
            avg_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg        <= pc_next;
            tick_freq_reg <= tick_freq_next;
            warmup_reg    <= warmup_next;
            steady_reg    <= steady_next;
            restart_reg   <= restart_next;
            start_reg     <= start_next;
            avg_reg       <= avg_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        div_reg   <= div_next;
        num_reg   <= num_next;
        quo_reg   <= quo_next;
        cnt_reg   <= cnt_next;
        n_reg     <= n_next;
        rate_reg  <= rate_next;
        alpha_reg <= alpha_next;
        diff_reg  <= diff_next;
        neg_reg   <= neg_next;
        prod_reg  <= prod_next;
        out_reg   <= out_next;
    end

    // remainder stays below a nonzero divisor throughout the division loops
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ((pc_reg == PC_RATE_LOOP || pc_reg == PC_ALPHA_LOOP) && div_reg != '0)
        |-> rem_reg < div_reg)
        else $error("divider remainder not below divisor");

    // step counter never runs out inside a loop
    a_cnt_live: assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg == PC_RATE_LOOP || pc_reg == PC_ALPHA_LOOP) |-> cnt_reg != '0)
        else $error("divider loop entered with zero step count");

    // the alpha division only runs in warmup, on a nonzero frame number
    a_warmup_div: assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg == PC_ALPHA_LOAD) |-> (!steady && n_reg != '0))
        else $error("alpha division outside warmup");

    // the blend weight never exceeds one
    a_alpha_max: assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg == PC_MUL) |-> alpha_reg <= ONE_Q16)
        else $error("alpha above one");

    // a new result word appears only from the emit step
    a_emit_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(pc_reg) == PC_EMIT)
        else $error("output word raised outside emit step");

endmodule
